[sv/bfb_pkg.sv]
// Shared types, codes and helpers of the bond force block.
`default_nettype none

package bfb_pkg;

    localparam int MUL_W    = 64;
    localparam int PROD_W   = 128;
    localparam int HALF_W   = 32;
    localparam int REG_W    = 32;
    localparam int RAD_W    = 31;
    localparam int DIM_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int PI_SHIFT = 29;
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    localparam logic [CFG_IDX_W-1:0] CFG_KN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM = 2'd2;
    localparam logic [DIM_W-1:0]     DIM_2D  = 2'd2;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [2:0] OP_SQ      = 3'd0;
    localparam logic [2:0] OP_FORCE   = 3'd1;
    localparam logic [2:0] OP_CONTRIB = 3'd2;
    localparam logic [2:0] OP_R2      = 3'd3;
    localparam logic [2:0] OP_AREA    = 3'd4;
    localparam logic [2:0] OP_TA      = 3'd5;

    typedef struct packed {
        logic       load;
        logic       diff;
        logic       mul_start;
        logic [2:0] mul_op;
        logic       sqrt_start;
        logic       div_start;
        logic [1:0] axis;
        logic       acc_add;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic intact;
        logic len_zero;
        logic brk_test;
        logic axes3;
        logic out_free;
    } stat_t;

    // right shift, saturated to 64 bits
    function automatic logic [MUL_W-1:0] shr_sat(input logic [PROD_W-1:0] a, input int k);
        logic [PROD_W-1:0] t;
        t = a >> k;
        if (t[PROD_W-1:MUL_W] != '0)
            return '1;
        return t[MUL_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/bfb_mul.sv]
// Shared 64x64 multiplier built from four 32x32 partial products.
`default_nettype none

module bfb_mul (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [bfb_pkg::MUL_W-1:0]    a,
    input  wire logic [bfb_pkg::MUL_W-1:0]    b,
    output logic                              done,
    output logic [bfb_pkg::PROD_W-1:0]        p
);

    localparam int HW = bfb_pkg::HALF_W;

    logic [bfb_pkg::MUL_W-1:0]  a_reg;
    logic [bfb_pkg::MUL_W-1:0]  b_reg;
    logic [2:0]                 cnt_reg;
    logic                       busy_reg;
    logic                       ppv_reg;
    logic                       done_reg;
    logic [2*HW-1:0]            pp_reg;
    logic [1:0]                 sh_reg;
    logic [bfb_pkg::PROD_W-1:0] acc_reg;

    logic [HW-1:0]              a_half;
    logic [HW-1:0]              b_half;
    logic [2*HW-1:0]            prod;
    logic [bfb_pkg::PROD_W-1:0] pp_shifted;

    assign a_half = cnt_reg[1] ? a_reg[2*HW-1:HW] : a_reg[HW-1:0];
    assign b_half = cnt_reg[0] ? b_reg[2*HW-1:HW] : b_reg[HW-1:0];
    assign prod   = (2*HW)'(a_half) * (2*HW)'(b_half);

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shifted = {{(2*HW){1'b0}}, pp_reg};
            2'd1:    pp_shifted = {{HW{1'b0}}, pp_reg, {HW{1'b0}}};
            default: pp_shifted = {pp_reg, {(2*HW){1'b0}}};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                ppv_reg  <= 1'b0;
                cnt_reg  <= 3'd0;
            end
            else if (busy_reg)
            begin
                ppv_reg <= (cnt_reg != 3'd4);
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd4)
            begin
                pp_reg <= prod;
                sh_reg <= {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
            end
            if (ppv_reg)
                acc_reg <= acc_reg + pp_shifted;
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

`default_nettype wire

[sv/bfb_dp.sv]
// Datapath: operand registers, root and divider units, sums and output word.
`default_nettype none

module bfb_dp #(
    parameter int CW = 32,
    parameter int F  = 16,
    parameter int SW = 48
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [bfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bfb_pkg::REG_W-1:0]       cfg_data,
    input  wire logic [((6*CW+3*bfb_pkg::RAD_W+2+7)/8)*8-1:0] s_tdata,
    input  wire logic                            s_tlast,
    input  wire bfb_pkg::cmd_t                   cmd,
    output bfb_pkg::stat_t                       stat,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [((1+3*SW+7)/8)*8-1:0]          m_tdata,
    output logic                                 m_tlast
);

    localparam int RW_  = bfb_pkg::RAD_W;
    localparam int LW   = CW + 1;
    localparam int SQW  = 2 * LW;
    localparam int RMW  = LW + 3;
    localparam int DW   = (LW > RW_) ? LW : RW_;
    localparam int QW   = F + 1;
    localparam int SCW  = $clog2(LW + 1);
    localparam int DCW  = $clog2(QW + 1);
    localparam int OUT_W = ((1 + 3*SW + 7) / 8) * 8;
    localparam int OFF_REST = 6 * CW;
    localparam int OFF_ROWN = OFF_REST + RW_;
    localparam int OFF_RNB  = OFF_ROWN + RW_;
    localparam int OFF_INT  = OFF_RNB + RW_;
    localparam int OFF_UNB  = OFF_INT + 1;
    localparam logic [bfb_pkg::MUL_W-1:0] LIM = bfb_pkg::MUL_W'(1) << (SW - 1);
    localparam logic signed [SW+1:0] SMAX = $signed({3'b000, {(SW-1){1'b1}}});
    localparam logic signed [SW+1:0] SMIN = $signed({3'b111, {(SW-1){1'b0}}});

    // configuration
    logic [bfb_pkg::REG_W-1:0] kn_reg;
    logic [bfb_pkg::REG_W-1:0] ts_reg;
    logic [bfb_pkg::DIM_W-1:0] dim_reg;

    // bond operands
    logic signed [CW-1:0] own_reg [3];
    logic signed [CW-1:0] nb_reg [3];
    logic [RW_-1:0]       rest_reg;
    logic [RW_-1:0]       rown_reg;
    logic [RW_-1:0]       rnb_reg;
    logic                 intact_reg;
    logic                 unbr_reg;
    logic                 last_reg;
    logic                 conn_reg;
    logic signed [LW-1:0] d_reg [3];
    logic [SQW-1:0]       s_reg;

    // square root
    logic [SQW-1:0]       src_reg;
    logic [RMW-1:0]       rem_reg;
    logic [LW-1:0]        root_reg;
    logic [SCW-1:0]       scnt_reg;
    logic                 sbusy_reg;
    logic                 sdone_reg;

    // unit-vector divider
    logic [LW:0]          drem_reg;
    logic [QW-1:0]        q_reg;
    logic [DCW-1:0]       dcnt_reg;
    logic                 dbusy_reg;
    logic                 ddone_reg;

    logic [bfb_pkg::PROD_W-1:0] force_reg;
    logic [SW-1:0]              c_reg;
    logic [bfb_pkg::MUL_W-1:0]  r2_reg;
    logic [bfb_pkg::MUL_W-1:0]  area_reg;
    logic [2:0]                 mop_reg;
    logic signed [SW-1:0]       sum_reg [3];

    logic                 ov_reg;
    logic [OUT_W-1:0]     od_reg;
    logic                 ol_reg;

    // combinational
    logic [LW-1:0]              dm_sel;
    logic signed [LW-1:0]       d_sel;
    logic                       stretched;
    logic [DW-1:0]              diff;
    logic [RW_-1:0]             rmin;
    logic [bfb_pkg::MUL_W-1:0]  fmag;
    logic [bfb_pkg::MUL_W-1:0]  mul_a;
    logic [bfb_pkg::MUL_W-1:0]  mul_b;
    logic                       mul_done;
    logic [bfb_pkg::PROD_W-1:0] mul_p;
    logic [bfb_pkg::MUL_W-1:0]  contrib;
    logic [RMW-1:0]             rem_n;
    logic [RMW-1:0]             trial;
    logic                       dge;
    logic [LW:0]                dr;
    logic                       neg;
    logic signed [SW+1:0]       se;
    logic signed [SW+1:0]       ce;
    logic signed [SW+1:0]       tsum;
    logic [SW-1:0]              sat_sum;
    logic [SW-1:0]              fz;

    assign d_sel     = d_reg[cmd.axis];
    assign dm_sel    = d_sel[LW-1] ? LW'(-d_sel) : LW'(d_sel);
    assign stretched = DW'(root_reg) >= DW'(rest_reg);
    assign diff      = stretched ? DW'(root_reg) - DW'(rest_reg)
                                 : DW'(rest_reg) - DW'(root_reg);
    assign rmin      = (rown_reg < rnb_reg) ? rown_reg : rnb_reg;
    assign fmag      = bfb_pkg::shr_sat(force_reg, F);

    always_comb
    begin
        unique case (cmd.mul_op)
            bfb_pkg::OP_SQ:
            begin
                mul_a = bfb_pkg::MUL_W'(dm_sel);
                mul_b = bfb_pkg::MUL_W'(dm_sel);
            end
            bfb_pkg::OP_FORCE:
            begin
                mul_a = bfb_pkg::MUL_W'(kn_reg);
                mul_b = bfb_pkg::MUL_W'(diff);
            end
            bfb_pkg::OP_CONTRIB:
            begin
                mul_a = fmag;
                mul_b = bfb_pkg::MUL_W'(q_reg);
            end
            bfb_pkg::OP_R2:
            begin
                mul_a = bfb_pkg::MUL_W'(rmin);
                mul_b = bfb_pkg::MUL_W'(rmin);
            end
            bfb_pkg::OP_AREA:
            begin
                mul_a = r2_reg;
                mul_b = bfb_pkg::MUL_W'(bfb_pkg::PI_Q29);
            end
            default:
            begin
                mul_a = bfb_pkg::MUL_W'(ts_reg);
                mul_b = area_reg;
            end
        endcase
    end

    bfb_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    assign contrib = bfb_pkg::shr_sat(mul_p, F);

    // one root digit per cycle
    assign rem_n = {rem_reg[RMW-3:0], src_reg[SQW-1 -: 2]};
    assign trial = RMW'({root_reg, 2'b01});

    // one quotient bit per cycle
    assign dge = drem_reg >= {1'b0, root_reg};
    assign dr  = dge ? drem_reg - {1'b0, root_reg} : drem_reg;

    // saturating accumulate
    assign neg     = (!stretched) ^ d_sel[LW-1];
    assign se      = (SW+2)'(sum_reg[cmd.axis]);
    assign ce      = $signed({2'b00, c_reg});
    assign tsum    = neg ? se - ce : se + ce;
    assign sat_sum = (tsum > SMAX) ? SMAX[SW-1:0] :
                     (tsum < SMIN) ? SMIN[SW-1:0] : tsum[SW-1:0];

    assign fz = (dim_reg != bfb_pkg::DIM_2D) ? sum_reg[2] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kn_reg  <= bfb_pkg::REG_W'(65536);
            ts_reg  <= bfb_pkg::REG_W'(65536);
            dim_reg <= bfb_pkg::DIM_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bfb_pkg::CFG_KN:  kn_reg  <= cfg_data;
                bfb_pkg::CFG_TS:  ts_reg  <= cfg_data;
                bfb_pkg::CFG_DIM: dim_reg <= cfg_data[bfb_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbusy_reg <= 1'b0;
            sdone_reg <= 1'b0;
            scnt_reg  <= '0;
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
            ov_reg    <= 1'b0;
            for (int a = 0; a < 3; a++)
                sum_reg[a] <= '0;
        end
        else
        begin
            sdone_reg <= 1'b0;
            ddone_reg <= 1'b0;
            if (cmd.sqrt_start)
            begin
                sbusy_reg <= 1'b1;
                scnt_reg  <= SCW'(LW);
            end
            else if (sbusy_reg)
            begin
                scnt_reg <= scnt_reg - SCW'(1);
                if (scnt_reg == SCW'(1))
                begin
                    sbusy_reg <= 1'b0;
                    sdone_reg <= 1'b1;
                end
            end
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= DCW'(QW);
            end
            else if (dbusy_reg)
            begin
                dcnt_reg <= dcnt_reg - DCW'(1);
                if (dcnt_reg == DCW'(1))
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
                if (last_reg)
                    for (int a = 0; a < 3; a++)
                        sum_reg[a] <= '0;
            end
            else
            begin
                if (m_tready)
                    ov_reg <= 1'b0;
                if (cmd.acc_add)
                    sum_reg[cmd.axis] <= sat_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                own_reg[a] <= s_tdata[a*CW +: CW];
                nb_reg[a]  <= s_tdata[(a+3)*CW +: CW];
            end
            rest_reg   <= s_tdata[OFF_REST +: RW_];
            rown_reg   <= s_tdata[OFF_ROWN +: RW_];
            rnb_reg    <= s_tdata[OFF_RNB +: RW_];
            intact_reg <= s_tdata[OFF_INT];
            unbr_reg   <= s_tdata[OFF_UNB];
            conn_reg   <= s_tdata[OFF_INT];
            last_reg   <= s_tlast;
        end
        if (cmd.diff)
        begin
            for (int a = 0; a < 3; a++)
                d_reg[a] <= LW'(nb_reg[a]) - LW'(own_reg[a]);
            s_reg <= '0;
        end
        if (cmd.mul_start)
            mop_reg <= cmd.mul_op;
        if (mul_done)
        begin
            case (mop_reg)
                bfb_pkg::OP_SQ:      s_reg     <= s_reg + mul_p[SQW-1:0];
                bfb_pkg::OP_FORCE:   force_reg <= mul_p;
                bfb_pkg::OP_CONTRIB: c_reg <= (contrib > LIM) ? LIM[SW-1:0] : contrib[SW-1:0];
                bfb_pkg::OP_R2:      r2_reg    <= mul_p[bfb_pkg::MUL_W-1:0];
                bfb_pkg::OP_AREA:
                    area_reg <= bfb_pkg::shr_sat(mul_p, F + bfb_pkg::PI_SHIFT);
                default:
                    if (force_reg > mul_p)
                        conn_reg <= 1'b0;
            endcase
        end
        if (cmd.sqrt_start)
        begin
            src_reg  <= s_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (sbusy_reg)
        begin
            src_reg <= src_reg << 2;
            if (rem_n >= trial)
            begin
                rem_reg  <= rem_n - trial;
                root_reg <= {root_reg[LW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_n;
                root_reg <= {root_reg[LW-2:0], 1'b0};
            end
        end
        if (cmd.div_start)
        begin
            drem_reg <= (LW+1)'(dm_sel);
            q_reg    <= '0;
        end
        else if (dbusy_reg)
        begin
            q_reg    <= {q_reg[QW-2:0], dge};
            drem_reg <= {dr[LW-1:0], 1'b0};
        end
        if (cmd.emit)
        begin
            od_reg <= OUT_W'({fz, sum_reg[1], sum_reg[0], conn_reg});
            ol_reg <= last_reg;
        end
    end

    assign stat.mul_done  = mul_done;
    assign stat.sqrt_done = sdone_reg;
    assign stat.div_done  = ddone_reg;
    assign stat.intact    = intact_reg;
    assign stat.len_zero  = (root_reg == '0);
    assign stat.brk_test  = stretched && (diff != '0) && !unbr_reg;
    assign stat.axes3     = (dim_reg != bfb_pkg::DIM_2D);
    assign stat.out_free  = !ov_reg || m_tready;

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;

endmodule

`default_nettype wire

[sv/bfb_ctrl.sv]
// Controller: sequences the multiplier, root and divider for one bond.
`default_nettype none

module bfb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire bfb_pkg::stat_t stat,
    output bfb_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_MULW  = 4'd3;
    localparam logic [3:0] S_SQRT  = 4'd4;
    localparam logic [3:0] S_SQRTW = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DIVW  = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] op_reg;
    logic [2:0] op_next;
    logic [1:0] axis_reg;
    logic [1:0] axis_next;
    logic       last_ax;

    assign last_ax  = (axis_reg == bfb_pkg::AX_Z) ||
                      (axis_reg == bfb_pkg::AX_Y && !stat.axes3);
    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        axis_next  = axis_reg;
        cmd.axis   = axis_reg;
        cmd.mul_op = op_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIFF;
                end
            S_DIFF:
            begin
                cmd.diff = 1'b1;
                if (stat.intact)
                begin
                    op_next    = bfb_pkg::OP_SQ;
                    axis_next  = bfb_pkg::AX_X;
                    state_next = S_MUL;
                end
                else
                    state_next = S_EMIT;
            end
            S_MUL:
            begin
                cmd.mul_start = 1'b1;
                state_next    = S_MULW;
            end
            S_MULW:
                if (stat.mul_done)
                begin
                    unique case (op_reg)
                        bfb_pkg::OP_SQ:
                            if (last_ax)
                                state_next = S_SQRT;
                            else
                            begin
                                axis_next  = axis_reg + 2'd1;
                                state_next = S_MUL;
                            end
                        bfb_pkg::OP_FORCE:
                        begin
                            axis_next  = bfb_pkg::AX_X;
                            state_next = S_DIV;
                        end
                        bfb_pkg::OP_CONTRIB:
                            state_next = S_ACC;
                        bfb_pkg::OP_R2:
                        begin
                            op_next    = bfb_pkg::OP_AREA;
                            state_next = S_MUL;
                        end
                        bfb_pkg::OP_AREA:
                        begin
                            op_next    = bfb_pkg::OP_TA;
                            state_next = S_MUL;
                        end
                        default:
                            state_next = S_EMIT;
                    endcase
                end
            S_SQRT:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRTW;
            end
            S_SQRTW:
                if (stat.sqrt_done)
                begin
                    if (stat.len_zero)
                        state_next = S_EMIT;
                    else
                    begin
                        op_next    = bfb_pkg::OP_FORCE;
                        state_next = S_MUL;
                    end
                end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIVW;
            end
            S_DIVW:
                if (stat.div_done)
                begin
                    op_next    = bfb_pkg::OP_CONTRIB;
                    state_next = S_MUL;
                end
            S_ACC:
            begin
                cmd.acc_add = 1'b1;
                if (!last_ax)
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_DIV;
                end
                else if (stat.brk_test)
                begin
                    op_next    = bfb_pkg::OP_R2;
                    state_next = S_MUL;
                end
                else
                    state_next = S_EMIT;
            end
            S_EMIT:
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= bfb_pkg::OP_SQ;
            axis_reg  <= bfb_pkg::AX_X;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            axis_reg  <= axis_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result written while output word still held");

    a_mul_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |=> !stat.mul_done)
        else $error("multiplier finished right after start");

    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.mul_done |-> state_reg == S_MULW)
        else $error("multiplier result arrived outside wait state");

    a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.sqrt_done |-> state_reg == S_SQRTW)
        else $error("root result arrived outside wait state");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_DIVW)
        else $error("divider result arrived outside wait state");

endmodule

`default_nettype wire

[sv/bond_force_with_breakage.sv]
// Bond spring force with breakage.
// Input stream: one word per bond of a particle (positions, rest length, radii,
// flags); s_tlast marks the particle's final bond. Output stream: one word per
// bond with the bond's new connected flag and the running x/y/z force sums;
// m_tlast says the sums are final, after which they clear.
// A skipped bond goes straight to its output write; an intact bond runs the
// squares, the root, the force product and, per axis, the unit divider and
// the contribution product, plus the break test when it runs.
// The work is done by the shared 4-pass multiplier, the one-digit-per-cycle
// root over COORD_WIDTH+1 digits and the one-bit-per-cycle unit divider run
// once per axis.
// One word is worked on at a time; s_tready is high only while idle. The
// result sits in an output register, so a new word is accepted while the
// previous result waits; a stalled m_tready holds the block before its write.
// Reset clears the sums and loads stiffness 1.0, strength 1.0, three axes.
// Configuration writes must go in while idle; the block does not enforce it.
`default_nettype none

module bond_force_with_breakage #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16,
    parameter int SUM_WIDTH   = 48
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bfb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bfb_pkg::REG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // own_x, own_y, own_z, neighbor_x, neighbor_y, neighbor_z, rest_length,
    // own_radius, neighbor_radius, bond_intact, neighbor_unbreakable
    input  wire logic [((6*COORD_WIDTH+3*bfb_pkg::RAD_W+2+7)/8)*8-1:0] s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // still_connected, force_sum_x, force_sum_y, force_sum_z
    output logic [((1+3*SUM_WIDTH+7)/8)*8-1:0] m_tdata,
    output logic                               m_tlast
);

    bfb_pkg::cmd_t  cmd;
    bfb_pkg::stat_t stat;

    bfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfb_dp #(
        .CW (COORD_WIDTH),
        .F  (FRAC_BITS),
        .SW (SUM_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
